>>> hdl/lbq_pkg.sv
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared types, constants and helpers for the leaky bucket packet queue.
// ----------------------------------------------------------------------------
package lbq_pkg;

  // Storage geometry
  localparam int MAX_DEPTH   = 16;
  localparam int PACKET_BITS = 40;
  localparam int IDX_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MAX_DEPTH + 1);

  // Port field widths
  localparam int KIND_W = 3;
  localparam int FILL_W = 5;
  localparam int CAP_W  = 5;
  localparam int IVL_W  = 8;
  localparam int CFG_W  = 8;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET      = CAP_W'(10);
  localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(5);

  // Result codes
  typedef enum logic [KIND_W-1:0] {
    EV_ACCEPT = 3'd0,
    EV_DROP   = 3'd1,
    EV_LEAK   = 3'd2,
    EV_EMPTY  = 3'd3,
    EV_IDLE   = 3'd4
  } kind_t;

  // Input opcodes
  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  // Decision handed from the control unit to the top level on a transfer
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    kind_t             kind;
    logic [CNT_W-1:0]  fill;
  } op_req_t;

  // Capacity as used: zero acts as one, clamp to the store depth
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (int'(cap) > MAX_DEPTH) begin
      res = CNT_W'(MAX_DEPTH);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

  // Circular index step with wrap at the capacity
  function automatic logic [IDX_W-1:0] idx_advance(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] inc;
    logic [IDX_W-1:0] res;
    inc = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
    if (inc >= (CNT_W+1)'(cap)) begin
      res = '0;
    end else begin
      res = inc[IDX_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/lbq_store.sv
// ----------------------------------------------------------------------------
// lbq_store
// Packet storage: single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lbq_store (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic                            rd_en,
  input  logic [lbq_pkg::IDX_W-1:0]       addr,
  input  logic [lbq_pkg::PACKET_BITS-1:0] wr_data,
  output logic [lbq_pkg::PACKET_BITS-1:0] rd_data
);
  import lbq_pkg::*;

  logic [PACKET_BITS-1:0] mem [MAX_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> hdl/lbq_ctrl.sv
// ----------------------------------------------------------------------------
// lbq_ctrl
// Queue pointers, fill count, tick counter and configuration registers.
// Decides each item's event on its transfer and issues the store access.
// ----------------------------------------------------------------------------
module lbq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_xfer,
  input  logic                      op,
  input  logic                      cfg_xfer,
  input  logic                      cfg_index,
  input  logic [lbq_pkg::CFG_W-1:0] cfg_data,
  output lbq_pkg::op_req_t          req
);
  import lbq_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [IVL_W-1:0] interval;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IVL_W-1:0] tick, tick_next;

  logic [CNT_W-1:0] cap_eff;
  logic [IVL_W-1:0] ivl_eff;
  logic [IVL_W:0]   tick_inc;

  assign cap_eff  = eff_capacity(capacity);
  assign ivl_eff  = (interval == '0) ? IVL_W'(1) : interval;
  assign tick_inc = (IVL_W+1)'(tick) + (IVL_W+1)'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      interval <= INTERVAL_RESET;
    end else if (cfg_xfer) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        CFG_INTERVAL: interval <= cfg_data[IVL_W-1:0];
        default:      ;
      endcase
    end
  end

  // Event decision and next pointer values
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    tick_next  = tick;
    req.wr_en  = 1'b0;
    req.rd_en  = 1'b0;
    req.addr   = tail;
    req.kind   = EV_IDLE;
    if (op_t'(op) == OP_ARRIVAL) begin
      if (count >= cap_eff) begin
        req.kind = EV_DROP;
      end else begin
        req.kind   = EV_ACCEPT;
        req.wr_en  = item_xfer;
        tail_next  = idx_advance(tail, cap_eff);
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (tick == '0) begin
        if (count == '0) begin
          req.kind = EV_EMPTY;
        end else begin
          req.kind   = EV_LEAK;
          req.rd_en  = item_xfer;
          req.addr   = head;
          head_next  = idx_advance(head, cap_eff);
          count_next = count - CNT_W'(1);
        end
      end
      tick_next = (tick_inc >= (IVL_W+1)'(ivl_eff)) ? '0 : tick_inc[IVL_W-1:0];
    end
    req.fill = count_next;
  end

  // Queue state update on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      tick  <= '0;
    end else if (item_xfer) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      tick  <= tick_next;
    end
  end

endmodule

>>> hdl/leaky_bucket_packet_queue.sv
// ----------------------------------------------------------------------------
// leaky_bucket_packet_queue
// Leaky bucket shaper over a circular packet store. An arrival is stored at
// the tail, or dropped and returned when the fill count has reached the
// capacity. A tick leaks the head packet when the tick counter is zero (or
// reports an empty bucket), then steps the counter modulo the leak interval.
// Every item yields exactly one result carrying the fill level after it.
// An item is taken in the transfer cycle, where pointers update and the
// store is written or read; in the busy state that follows, the registered
// store data is ready and the result enters the output register. A new item
// is taken while the previous result still waits in the output register;
// the block stalls only when a finished result cannot enter that register.
// Configuration writes are accepted every cycle and must only be issued
// while no item is in flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module leaky_bucket_packet_queue (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [lbq_pkg::PACKET_BITS-1:0] packet_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lbq_pkg::KIND_W-1:0]      event_kind,
  output logic [lbq_pkg::PACKET_BITS-1:0] packet_out,
  output logic [lbq_pkg::FILL_W-1:0]      fill_level,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [lbq_pkg::CFG_W-1:0]       cfg_data
);
  import lbq_pkg::*;

  state_t  state, state_next;
  op_req_t req;
  logic    item_xfer;
  logic    out_load;

  logic [PACKET_BITS-1:0] rd_data;
  kind_t                  pend_kind;
  logic [CNT_W-1:0]       pend_fill;
  logic [PACKET_BITS-1:0] pend_data;
  logic [PACKET_BITS-1:0] result_data;

  assign cfg_ready = 1'b1;
  assign item_xfer = in_valid && in_ready;

  lbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_xfer (item_xfer),
    .op        (op),
    .cfg_xfer  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req)
  );

  lbq_store u_store (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .rd_en   (req.rd_en),
    .addr    (req.addr),
    .wr_data (packet_data),
    .rd_data (rd_data)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (item_xfer) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the event of the item in flight
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      pend_kind <= req.kind;
      pend_fill <= req.fill;
      pend_data <= packet_data;
    end
  end

  // Packet for the result: store data on a leak, own data on a drop
  always_comb begin
    case (pend_kind)
      EV_LEAK: result_data = rd_data;
      EV_DROP: result_data = pend_data;
      default: result_data = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_kind <= KIND_W'(pend_kind);
      packet_out <= result_data;
      fill_level <= FILL_W'(pend_fill);
    end
  end

endmodule

>>> hdl/lbq_checker.sv
// ----------------------------------------------------------------------------
// lbq_checker
// Port-level checks on the leaky bucket packet queue, bound to the top level.
// ----------------------------------------------------------------------------
module lbq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lbq_pkg::KIND_W-1:0]      event_kind,
  input logic [lbq_pkg::PACKET_BITS-1:0] packet_out,
  input logic [lbq_pkg::FILL_W-1:0]      fill_level
);
  import lbq_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(event_kind) && $stable(packet_out) && $stable(fill_level))
    else $error("result changed while stalled");

  // Only one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Packet field is zero unless a packet was dropped or leaked
  a_zero_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_ACCEPT || event_kind == EV_EMPTY ||
                  event_kind == EV_IDLE) |-> packet_out == '0)
    else $error("packet data on an event without a packet");

  // A drop only happens with a non-empty bucket
  a_drop_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_DROP |-> fill_level != '0)
    else $error("drop reported with an empty bucket");

  // Fill level never exceeds the store depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(fill_level) <= MAX_DEPTH)
    else $error("fill level beyond store depth");

endmodule

bind leaky_bucket_packet_queue lbq_checker u_lbq_checker (.*);
